>>> sv/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and constants shared by the 3x3 Laplacian edge unit: pixel and result
// payloads, output queue entries, register codes and reset values.
// ----------------------------------------------------------------------------
package lpe_pkg;

  // input payload, one raster-order pixel
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pixel_t;

  // result payload
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic        last_of_run;
  } out_result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int OUT_COL_W = 11;
  localparam int OUT_ROW_W = 12;

  // one line-store entry holds the upper and the middle row pixel of a column
  localparam int LINE_W = 48;

  // result slots caused by one pixel, in emission order
  localparam int SLOT_INNER  = 0;  // delayed result for (c-1, r-1)
  localparam int SLOT_RIGHT  = 1;  // right border zero for (c, r-1)
  localparam int SLOT_BOTTOM = 2;  // bottom border zero for (c, r)
  localparam int SLOT_N      = 3;

  typedef struct packed {
    rgb_t                  val;
    logic [OUT_COL_W-1:0]  col;
    logic [OUT_ROW_W-1:0]  row;
    logic [SLOT_N-1:0]     mask;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_WIDTH_W = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RST  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RST = 13'd480;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

endpackage

>>> sv/lpe_line_store.sv
// ----------------------------------------------------------------------------
// lpe_line_store
// Single-port-read, single-port-write line memory holding the two previous
// rows of the frame, one entry per column, with registered read data.
// ----------------------------------------------------------------------------
module lpe_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lpe_pkg::LINE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lpe_pkg::LINE_W-1:0] wr_data
);

  logic [lpe_pkg::LINE_W-1:0] mem [DEPTH];
  logic [lpe_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/lpe_kernel.sv
// ----------------------------------------------------------------------------
// lpe_kernel
// Per-channel 3x3 Laplacian: 8 x centre minus the eight neighbors, clamped
// to 0..255.
// ----------------------------------------------------------------------------
module lpe_kernel (
  input  lpe_pkg::rgb_t       centre,
  input  lpe_pkg::rgb_t [7:0] nb,
  output lpe_pkg::rgb_t       result
);

  logic [10:0] sum_red;
  logic [10:0] sum_green;
  logic [10:0] sum_blue;

  function automatic logic [7:0] clamp8(input logic [7:0] c, input logic [10:0] s);
    logic signed [11:0] acc;
    begin
      acc = $signed({1'b0, c, 3'b000}) - $signed({1'b0, s});
      if (acc[11]) begin
        clamp8 = 8'd0;
      end else if (acc[10:8] != 3'd0) begin
        clamp8 = 8'hFF;
      end else begin
        clamp8 = acc[7:0];
      end
    end
  endfunction

  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int k = 0; k < 8; k++) begin
      sum_red   = sum_red   + 11'(nb[k].red);
      sum_green = sum_green + 11'(nb[k].green);
      sum_blue  = sum_blue  + 11'(nb[k].blue);
    end
  end

  assign result.red   = clamp8(centre.red,   sum_red);
  assign result.green = clamp8(centre.green, sum_green);
  assign result.blue  = clamp8(centre.blue,  sum_blue);

endmodule

>>> sv/lpe_out_queue.sv
// ----------------------------------------------------------------------------
// lpe_out_queue
// Result queue: one entry per pixel that has results, up to three of them;
// the head entry is sent one result per transfer, in slot order.
// ----------------------------------------------------------------------------
module lpe_out_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpe_pkg::q_push_t            push,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lpe_pkg::out_result_t        out_data,
  output logic [lpe_pkg::QCNT_W-1:0]  level
);

  lpe_pkg::q_entry_t store [lpe_pkg::QDEPTH];

  logic [lpe_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lpe_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lpe_pkg::QCNT_W-1:0] level_r, level_nxt;
  logic [lpe_pkg::SLOT_N-1:0] done_r, done_nxt;

  lpe_pkg::q_entry_t          head;
  logic [lpe_pkg::SLOT_N-1:0] rem;
  logic [lpe_pkg::SLOT_N-1:0] sel;
  logic                       last;
  logic                       take;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      store[wr_ptr_r] <= push.entry;
    end
  end

  assign head = store[rd_ptr_r];
  assign rem  = head.mask & ~done_r;

  always_comb begin
    sel = '0;
    if (rem[lpe_pkg::SLOT_INNER]) begin
      sel[lpe_pkg::SLOT_INNER] = 1'b1;
    end else if (rem[lpe_pkg::SLOT_RIGHT]) begin
      sel[lpe_pkg::SLOT_RIGHT] = 1'b1;
    end else begin
      sel[lpe_pkg::SLOT_BOTTOM] = 1'b1;
    end
  end

  assign last = ((rem & ~sel) == '0);

  always_comb begin
    out_data.out_red     = 8'd0;
    out_data.out_green   = 8'd0;
    out_data.out_blue    = 8'd0;
    out_data.out_col     = head.col;
    out_data.out_row     = head.row;
    out_data.last_of_run = last;
    if (sel[lpe_pkg::SLOT_INNER]) begin
      out_data.out_red   = head.val.red;
      out_data.out_green = head.val.green;
      out_data.out_blue  = head.val.blue;
      out_data.out_col   = head.col - 11'd1;
      out_data.out_row   = head.row - 12'd1;
    end else if (sel[lpe_pkg::SLOT_RIGHT]) begin
      out_data.out_row   = head.row - 12'd1;
    end
  end

  assign out_valid = (level_r != '0);
  assign take      = out_valid && out_ready;
  assign pop       = take && last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    done_nxt   = done_r;
    if (push.valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (take) begin
      if (last) begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
        done_nxt   = '0;
      end else begin
        done_nxt = done_r | sel;
      end
    end
    level_nxt = lpe_pkg::QCNT_W'(level_r + lpe_pkg::QCNT_W'(push.valid)
                                 - lpe_pkg::QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
      done_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
      done_r   <= done_nxt;
    end
  end

  assign level = level_r;

endmodule

>>> sv/laplacian_edge_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// laplacian_edge_3x3_rgb_unit
// Streaming 3x3 Laplacian edge detector for RGB pixels in raster order, with
// two rows held in a line memory and a 3x2 column window in registers.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (in_pixel_t)
//   out      output     out_valid / out_ready  out_data (out_result_t)
//   config   input      APB psel/penable/...   image_width @0, image_height @4
//
// One pixel is accepted per clock while the result queue has room; its results
// pass the stage 1 registers into a four-entry result queue and leave one per
// clock while out_ready is high. Pixels of the last row cause one to three
// results each, so there the input rate follows the output rate.
// Line memory is read at accept and written back the next cycle; a width of
// one forwards the pending write to the next read.
// Reset is synchronous; it clears counters, window and queue, no memory pass.
// A register write restarts the frame at column and row zero.
// ----------------------------------------------------------------------------
module laplacian_edge_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lpe_pkg::in_pixel_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lpe_pkg::out_result_t               out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpe_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lpe_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W  = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [lpe_pkg::CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [lpe_pkg::CFG_HEIGHT_W-1:0] cfg_height_r;
  logic                             cfg_wr;
  logic [WEFF_W-1:0]                w_eff;
  logic [HEFF_W-1:0]                h_eff;

  // frame position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             acc0;
  logic             col_last;
  logic             row_last;

  // stage 1
  logic                       s1_v_r;
  lpe_pkg::rgb_t              s1_pix_r;
  logic [COL_W-1:0]           s1_col_r;
  logic [ROW_W-1:0]           s1_row_r;
  logic [lpe_pkg::SLOT_N-1:0] s1_mask_r;
  logic                       s1_int_r;
  logic                       fwd_r;
  lpe_pkg::rgb_t              fwd_top_r;
  lpe_pkg::rgb_t              fwd_mid_r;

  logic [lpe_pkg::LINE_W-1:0] rd_data;
  lpe_pkg::rgb_t              top_eff;
  lpe_pkg::rgb_t              mid_eff;
  lpe_pkg::rgb_t              pix0;
  lpe_pkg::rgb_t              win_r [6];
  lpe_pkg::rgb_t [7:0]        nb;
  lpe_pkg::rgb_t              k_out;

  lpe_pkg::q_push_t           q_push;
  logic [lpe_pkg::QCNT_W-1:0] q_level;

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= lpe_pkg::CFG_WIDTH_RST;
      cfg_height_r <= lpe_pkg::CFG_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        lpe_pkg::REG_IMAGE_WIDTH: begin
          cfg_width_r <= pwdata[lpe_pkg::CFG_WIDTH_W-1:0];
        end
        lpe_pkg::REG_IMAGE_HEIGHT: begin
          cfg_height_r <= pwdata[lpe_pkg::CFG_HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lpe_pkg::REG_IMAGE_WIDTH:  prdata = lpe_pkg::CFG_DATA_W'(cfg_width_r);
      lpe_pkg::REG_IMAGE_HEIGHT: prdata = lpe_pkg::CFG_DATA_W'(cfg_height_r);
      default:                   prdata = '0;
    endcase
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = HEFF_W'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(cfg_height_r);
    end
  end

  // ---- stage 0: accept, track position, read line memory
  assign in_ready = (4'(q_level) + 4'(s1_v_r)) < 4'(lpe_pkg::QDEPTH);
  assign acc0     = in_valid && in_ready;
  assign col_last = (WEFF_W'(col_r) == WEFF_W'(w_eff - WEFF_W'(1)));
  assign row_last = (HEFF_W'(row_r) == HEFF_W'(h_eff - HEFF_W'(1)));

  assign pix0.red   = in_data.in_red;
  assign pix0.green = in_data.in_green;
  assign pix0.blue  = in_data.in_blue;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc0) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : ROW_W'(row_r + 1'b1);
      end else begin
        col_nxt = COL_W'(col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= acc0;
      if (acc0) begin
        // same column still being written back: take it from stage 1
        fwd_r <= s1_v_r && (s1_col_r == col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc0) begin
      s1_pix_r  <= pix0;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_int_r  <= (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
      s1_mask_r[lpe_pkg::SLOT_INNER]  <= (row_r != '0) && (col_r != '0);
      s1_mask_r[lpe_pkg::SLOT_RIGHT]  <= (row_r != '0) && col_last;
      s1_mask_r[lpe_pkg::SLOT_BOTTOM] <= row_last;
      fwd_top_r <= mid_eff;
      fwd_mid_r <= s1_pix_r;
    end
  end

  lpe_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (acc0),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_v_r),
    .wr_addr (s1_col_r),
    .wr_data ({mid_eff, s1_pix_r})
  );

  // ---- stage 1: window, kernel, write back, push results
  assign top_eff = fwd_r ? fwd_top_r : lpe_pkg::rgb_t'(rd_data[lpe_pkg::LINE_W-1:24]);
  assign mid_eff = fwd_r ? fwd_mid_r : lpe_pkg::rgb_t'(rd_data[23:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      // shift column c-1 into c-2, load the new column
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top_eff;
      win_r[1] <= mid_eff;
      win_r[2] <= s1_pix_r;
    end
  end

  assign nb = {win_r[3], win_r[4], win_r[5], win_r[0], win_r[2],
               top_eff, mid_eff, s1_pix_r};

  lpe_kernel u_kernel (
    .centre (win_r[1]),
    .nb     (nb),
    .result (k_out)
  );

  assign q_push.valid      = s1_v_r && (s1_mask_r != '0);
  assign q_push.entry.val  = s1_int_r ? k_out : '0;
  assign q_push.entry.col  = lpe_pkg::OUT_COL_W'(s1_col_r);
  assign q_push.entry.row  = lpe_pkg::OUT_ROW_W'(s1_row_r);
  assign q_push.entry.mask = s1_mask_r;

  lpe_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (q_level)
  );

`ifndef ASSERT_OFF
  // forwarding only happens when every pixel lands in column zero
  a_fwd_width_one: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && fwd_r) |-> (w_eff == WEFF_W'(1)))
    else $error("line store forward with width above one");

  // column position stays inside the current row
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(w_eff))
    else $error("column count beyond image width");

  // accept guard leaves room for every push
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> (q_level < lpe_pkg::QCNT_W'(lpe_pkg::QDEPTH)))
    else $error("result queue overflow");

  // a transfer on the input reaches stage 1 in the next cycle
  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted pixel missing in stage 1");
`endif

endmodule

>>> dv/laplacian_edge_3x3_rgb_unit_tb.sv
// ----------------------------------------------------------------------------
// laplacian_edge_3x3_rgb_unit_tb
// Self-checking bench for the 3x3 Laplacian edge unit. It streams RGB pixels
// over frames of many sizes. These include the register extremes, frame
// restarts in mid-frame, narrow and short frames, and one long output stall.
// A scoreboard class keeps its own copy of the line stores, the window and
// the frame counters. It predicts each pixel's results and compares them, in
// order, with what leaves the result channel.
// ----------------------------------------------------------------------------
module laplacian_edge_3x3_rgb_unit_tb;

  localparam int FRAME_MAX_W    = 2048;
  localparam int FRAME_MAX_H    = 4096;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_PIXELS  = 280;
  localparam int EXTREME_PIXELS = 40;
  localparam int REPORT_LIMIT   = 10;

  class edge_scoreboard;
    lpe_pkg::rgb_t                    upper_line[FRAME_MAX_W];
    lpe_pkg::rgb_t                    middle_line[FRAME_MAX_W];
    lpe_pkg::rgb_t                    window[6];
    int                               col_cnt;
    int                               row_cnt;
    logic [lpe_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [lpe_pkg::CFG_HEIGHT_W-1:0] height_reg;
    lpe_pkg::out_result_t             expected_results[$];
    int                               mismatches;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = lpe_pkg::CFG_WIDTH_RST;
      height_reg = lpe_pkg::CFG_HEIGHT_RST;
      mismatches = 0;
    endfunction

    static function int active_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    static function logic [7:0] clamp_byte(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function lpe_pkg::rgb_t laplacian(lpe_pkg::rgb_t nb[8], lpe_pkg::rgb_t centre);
      int            acc_r;
      int            acc_g;
      int            acc_b;
      lpe_pkg::rgb_t res;
      acc_r = 8 * int'(centre.red);
      acc_g = 8 * int'(centre.green);
      acc_b = 8 * int'(centre.blue);
      for (int k = 0; k < 8; k++) begin
        acc_r -= int'(nb[k].red);
        acc_g -= int'(nb[k].green);
        acc_b -= int'(nb[k].blue);
      end
      res.red   = clamp_byte(acc_r);
      res.green = clamp_byte(acc_g);
      res.blue  = clamp_byte(acc_b);
      return res;
    endfunction

    function lpe_pkg::out_result_t make_result(lpe_pkg::rgb_t v, int col, int row);
      lpe_pkg::out_result_t res;
      res.out_red     = v.red;
      res.out_green   = v.green;
      res.out_blue    = v.blue;
      res.out_col     = lpe_pkg::OUT_COL_W'(col);
      res.out_row     = lpe_pkg::OUT_ROW_W'(row);
      res.last_of_run = 1'b0;
      return res;
    endfunction

    function void note_config(logic idx, logic [lpe_pkg::CFG_DATA_W-1:0] value);
      if (idx == lpe_pkg::REG_IMAGE_WIDTH) width_reg = value[lpe_pkg::CFG_WIDTH_W-1:0];
      else height_reg = value[lpe_pkg::CFG_HEIGHT_W-1:0];
      // any write restarts the frame, line stores keep their contents
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function void note_pixel(lpe_pkg::in_pixel_t p);
      int                   w;
      int                   h;
      int                   c;
      int                   r;
      lpe_pkg::rgb_t        pix;
      lpe_pkg::rgb_t        top;
      lpe_pkg::rgb_t        mid;
      lpe_pkg::rgb_t        val;
      lpe_pkg::rgb_t        nb[8];
      lpe_pkg::out_result_t burst[$];
      lpe_pkg::out_result_t tail;
      w = active_dim(width_reg, FRAME_MAX_W);
      h = active_dim(height_reg, FRAME_MAX_H);
      c = col_cnt;
      r = row_cnt;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      pix = {p.in_red, p.in_green, p.in_blue};
      top = upper_line[c];
      mid = middle_line[c];
      // results lag one row and one column behind the incoming pixel
      if (r >= 1) begin
        if (c >= 1) begin
          val = '0;
          if (c >= 2 && r >= 2 && r <= h - 1) begin
            nb  = '{window[3], window[4], window[5], window[0], window[2], top, mid, pix};
            val = laplacian(nb, window[1]);
          end
          burst.push_back(make_result(val, c - 1, r - 1));
        end
        if (c == w - 1) burst.push_back(make_result('0, c, r - 1));
      end
      // bottom border zeros go out right away
      if (r == h - 1) burst.push_back(make_result('0, c, r));
      if (burst.size() > 0) begin
        tail = burst.pop_back();
        tail.last_of_run = 1'b1;
        burst.push_back(tail);
      end
      foreach (burst[i]) expected_results.push_back(burst[i]);

      upper_line[c]  = mid;
      middle_line[c] = pix;
      window[3] = window[0];
      window[4] = window[1];
      window[5] = window[2];
      window[0] = top;
      window[1] = mid;
      window[2] = pix;

      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
    endfunction

    function void check_result(lpe_pkg::out_result_t got);
      lpe_pkg::out_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                   got.out_red, got.out_green, got.out_blue, got.out_col, got.out_row,
                   got.last_of_run);
        return;
      end
      want = expected_results.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_col !== want.out_col ||
          got.out_row !== want.out_row || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch: expected r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                   want.out_red, want.out_green, want.out_blue, want.out_col, want.out_row,
                   want.last_of_run);
          $display("          got      r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                   got.out_red, got.out_green, got.out_blue, got.out_col, got.out_row,
                   got.last_of_run);
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  lpe_pkg::in_pixel_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  lpe_pkg::out_result_t           out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lpe_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lpe_pkg::CFG_DATA_W-1:0] pwdata;
  logic [lpe_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  bit            calm;
  bit            hold_request;
  int            stall_cycles = 0;
  edge_scoreboard sb = new();

  laplacian_edge_3x3_rgb_unit #(
    .MAX_WIDTH  (FRAME_MAX_W),
    .MAX_HEIGHT (FRAME_MAX_H)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: random back-pressure plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("laplacian_edge_3x3_rgb_unit_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic lpe_pkg::in_pixel_t random_pixel();
    return {pick_level(), pick_level(), pick_level()};
  endfunction

  // enter and leave on a falling edge
  task automatic send_pixel(input lpe_pkg::in_pixel_t p);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_config(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_write(lpe_pkg::REG_IMAGE_WIDTH, w);
    cfg_write(lpe_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // drop valid, wait out every expected result, then let row-zero work finish
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic stream_random(input int n);
    repeat (n) send_pixel(random_pixel());
    drain();
  endtask

  task automatic send_plus_frame(input lpe_pkg::rgb_t centre, input lpe_pkg::rgb_t around);
    for (int i = 0; i < 9; i++) send_pixel(lpe_pkg::in_pixel_t'(i == 4 ? centre : around));
    drain();
  endtask

  initial begin
    int random_done;
    int length;
    int w;
    int h;
    int wa;
    int ha;
    int phase;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single interior pixel: clamp high, clamp low and an in-range value
    set_frame(3, 3);
    send_plus_frame({8'd255, 8'd0, 8'd40}, {8'd0, 8'd255, 8'd20});
    send_plus_frame({8'd0, 8'd255, 8'd200}, {8'd255, 8'd0, 8'd190});
    // zero registers count as one, narrow and short frames give border zeros
    set_frame(0, 2);
    stream_random(3);
    set_frame(2, 0);
    stream_random(2);

    // hold the result side so the queue fills and stalls the input
    set_frame(5, 5);
    calm         = 1'b1;
    hold_request = 1'b1;
    stream_random(60);

    // largest sizes, registers above the limits saturate
    set_frame(4095, 1);
    stream_random(EXTREME_PIXELS);
    set_frame(1, 8191);
    stream_random(EXTREME_PIXELS);
    set_frame(FRAME_MAX_W, FRAME_MAX_H);
    stream_random(20);
    calm = 1'b0;

    random_done = 0;
    phase       = 0;
    w           = FRAME_MAX_W;
    h           = FRAME_MAX_H;
    while (random_done < RANDOM_PIXELS) begin
      calm = (phase >= 4 && phase < 8);
      case ($urandom_range(9))
        0: begin
          w = $urandom_range(2);
          h = $urandom_range(2);
          set_frame(w, h);
        end
        1, 2: begin
          // rewrite one register to restart the frame mid-stream
          if ($urandom_range(1) == 0) cfg_write(lpe_pkg::REG_IMAGE_WIDTH, w);
          else cfg_write(lpe_pkg::REG_IMAGE_HEIGHT, h);
        end
        default: begin
          w = $urandom_range(1, 7);
          h = $urandom_range(1, 6);
          set_frame(w, h);
        end
      endcase
      wa = edge_scoreboard::active_dim(w, FRAME_MAX_W);
      ha = edge_scoreboard::active_dim(h, FRAME_MAX_H);
      if ($urandom_range(9) < 7 && wa * ha <= 60) length = wa * ha * $urandom_range(1, 2);
      else length = $urandom_range(1, 24);
      stream_random(length);
      random_done += length;
      phase++;
    end
    calm = 1'b0;

    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("laplacian_edge_3x3_rgb_unit_tb: clean");
    end else begin
      $display("laplacian_edge_3x3_rgb_unit_tb: errors");
    end
    $finish;
  end

endmodule
